[rtl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned OpW     = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 7;

  // Cells per group of the registered rear-read tree
  localparam int unsigned GrpSize = 8;

  typedef logic [OccW-1:0] occ_t;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_REAR  = 3'd2,
    CMD_SHIFT_OUT  = 3'd3,
    CMD_ROTATE     = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    occ_t count;
  } cell_cmd_t;

endpackage

[rtl/deq_if.sv]
`timescale 1ns / 1ps

// Request channel: one operation per item
interface deq_in_if;
  import deq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         operation;
  logic signed [ValW-1:0] item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

// Result channel: one result per item, or one per stored entry for a list
interface deq_out_if;
  import deq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] out_value;
  logic                   last;
  logic [StatusW-1:0]     status;
  logic [OccW-1:0]        occupancy;

  modport source (output valid, output out_value, output last, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input out_value, input last, input status,
                  input occupancy, output ready);
endinterface

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Timing: push and pop front give their result in the cycle after the item is taken;
//   pop rear goes through the registered group OR stage, then the result register.
// Flow: one item at a time; the queue takes no new item while a pop rear or list
//   is in progress, and a list gives one result per stored entry as the row rotates.
// Reset: rst_ni (async, active low) empties the queue and drops any pending result;
//   cell contents are not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_in_if.sink     in_i,
  deq_out_if.source  out_o
);
  import deq_pkg::*;

  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned NumGrp = (DEPTH + GrpSize - 1) / GrpSize;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_REAR = 3'b010,
    ST_LIST = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       list_idx_q, list_idx_d;
  logic [DATA_WIDTH-1:0] part_q [NumGrp];
  logic [DATA_WIDTH-1:0] part_d [NumGrp];
  logic [DATA_WIDTH-1:0] vals   [DEPTH];
  logic [DATA_WIDTH-1:0] taps   [NumGrp*GrpSize];
  logic [DATA_WIDTH-1:0] push_val;
  logic [DATA_WIDTH-1:0] load_val;
  logic [DATA_WIDTH-1:0] rear_val;
  logic [ValW-1:0]       front_ext;
  logic [ValW-1:0]       rear_ext;
  cell_cmd_t             cmd;
  cmd_e                  cmd_op;
  logic                  rot_sel;
  logic                  part_load;
  logic                  out_free;
  logic                  in_acc;
  logic                  list_last;

  logic                  out_valid_q;
  logic [ValW-1:0]       out_value_q;
  logic                  out_last_q;
  status_e               out_status_q;
  occ_t                  out_occ_q;

  logic                  emit;
  logic [ValW-1:0]       e_val;
  logic                  e_last;
  status_e               e_status;
  logic [CntW-1:0]       e_occ;

  // Fit pushed values into the cell width and reported values back to 32 bits
  if (DATA_WIDTH <= ValW) begin : g_in_narrow
    assign push_val = in_i.item_value[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign push_val = {{(DATA_WIDTH-ValW){in_i.item_value[ValW-1]}}, in_i.item_value};
  end

  if (DATA_WIDTH >= ValW) begin : g_out_wide
    assign front_ext = vals[0][ValW-1:0];
    assign rear_ext  = rear_val[ValW-1:0];
  end else begin : g_out_narrow
    assign front_ext = {{(ValW-DATA_WIDTH){vals[0][DATA_WIDTH-1]}}, vals[0]};
    assign rear_ext  = {{(ValW-DATA_WIDTH){rear_val[DATA_WIDTH-1]}}, rear_val};
  end

  // Row of cells, front entry in cell 0
  assign cmd.op    = cmd_op;
  assign cmd.count = OccW'(count_q);
  assign load_val  = rot_sel ? vals[0] : push_val;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v;
    logic [DATA_WIDTH-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = load_val;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end

    deq_cell #(
      .DataWidth(DATA_WIDTH),
      .Index    (i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .load_i (load_val),
      .left_i (left_v),
      .right_i(right_v),
      .value_o(vals[i]),
      .tap_o  (taps[i])
    );
  end

  for (genvar i = DEPTH; i < NumGrp * GrpSize; i++) begin : g_pad
    assign taps[i] = '0;
  end

  // First level of the rear-read tree: OR each group of cell taps
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GrpSize; k++) begin
        part_d[g] = part_d[g] | taps[g*GrpSize + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (part_load) begin
      for (int g = 0; g < NumGrp; g++) begin
        part_q[g] <= part_d[g];
      end
    end
  end

  // Second level: OR the registered groups
  always_comb begin
    rear_val = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rear_val = rear_val | part_q[g];
    end
  end

  // Control: decode operations and sequence list and pop rear
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign list_last  = (list_idx_q == CntW'(count_q - 1'b1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    list_idx_d = list_idx_q;
    cmd_op     = CMD_HOLD;
    rot_sel    = 1'b0;
    part_load  = 1'b0;
    emit       = 1'b0;
    e_val      = '0;
    e_last     = 1'b1;
    e_status   = STAT_OK;
    e_occ      = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.operation) inside
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              emit = 1'b1;
              if (count_q == CntW'(DEPTH)) begin
                e_status = STAT_FULL;
              end else begin
                cmd_op  = (in_i.operation == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                            : CMD_PUSH_REAR;
                count_d = count_q + 1'b1;
                e_occ   = count_d;
              end
            end
            OP_POP_FRONT: begin
              emit = 1'b1;
              if (count_q == '0) begin
                e_status = STAT_EMPTY;
              end else begin
                cmd_op  = CMD_SHIFT_OUT;
                count_d = count_q - 1'b1;
                e_val   = front_ext;
                e_occ   = count_d;
              end
            end
            OP_POP_REAR: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = STAT_EMPTY;
              end else begin
                part_load = 1'b1;
                count_d   = count_q - 1'b1;
                state_d   = ST_REAR;
              end
            end
            OP_LIST: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = STAT_EMPTY;
              end else begin
                list_idx_d = '0;
                state_d    = ST_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REAR: begin
        if (out_free) begin
          emit    = 1'b1;
          e_val   = rear_ext;
          state_d = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          emit       = 1'b1;
          e_val      = front_ext;
          e_last     = list_last;
          cmd_op     = CMD_ROTATE;
          rot_sel    = 1'b1;
          list_idx_d = list_idx_q + 1'b1;
          if (list_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      list_idx_q  <= list_idx_d;
      out_valid_q <= emit || (out_valid_q && !out_o.ready);
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q  <= e_val;
      out_last_q   <= e_last;
      out_status_q <= e_status;
      out_occ_q    <= OccW'(e_occ);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

endmodule

[rtl/deq_cell.sv]
`timescale 1ns / 1ps

module deq_cell #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned Index     = 0
) (
  input  logic                  clk_i,
  input  deq_pkg::cell_cmd_t    cmd_i,
  input  logic [DataWidth-1:0]  load_i,
  input  logic [DataWidth-1:0]  left_i,
  input  logic [DataWidth-1:0]  right_i,
  output logic [DataWidth-1:0]  value_o,
  output logic [DataWidth-1:0]  tap_o
);
  import deq_pkg::*;

  logic [DataWidth-1:0] val_q, val_d;
  logic                 is_tail;
  logic                 is_rear;
  logic                 below_rear;

  // Locate this cell relative to the live region
  assign is_tail    = (cmd_i.count == OccW'(Index));
  assign is_rear    = (cmd_i.count == OccW'(Index + 1));
  assign below_rear = (OccW'(Index + 1) < cmd_i.count);

  // Pick the next value from the neighbors or the load bus
  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      CMD_PUSH_FRONT: val_d = left_i;
      CMD_PUSH_REAR: begin
        if (is_tail) val_d = load_i;
      end
      CMD_SHIFT_OUT:  val_d = right_i;
      CMD_ROTATE: begin
        if (is_rear) begin
          val_d = load_i;
        end else if (below_rear) begin
          val_d = right_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;
  // Offer the value only when this cell holds the rear entry
  assign tap_o   = is_rear ? val_q : '0;

endmodule

[rtl/deq_checker.sv]
`timescale 1ns / 1ps

module deq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [deq_pkg::ValW-1:0]     out_value_i,
  input logic                         out_last_i,
  input logic [deq_pkg::StatusW-1:0]  out_status_i,
  input logic [deq_pkg::OccW-1:0]     out_occ_i
);
  import deq_pkg::*;

  // A stalled item keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
      && $stable(out_last_i) && $stable(out_status_i) && $stable(out_occ_i))
    else $error("result changed while stalled");

  // New work is only taken when the result register drains
  a_in_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_ready_i)
    else $error("input taken while result blocked");

  // A refused push only happens at capacity
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_FULL |-> out_occ_i == OccW'(DEPTH)
      && out_value_i == '0 && out_last_i)
    else $error("full status below capacity");

  // Empty status carries a zero value and ends its item
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_EMPTY |-> out_occ_i == '0
      && out_value_i == '0 && out_last_i)
    else $error("bad empty result");

  // Occupancy never passes capacity
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_occ_i <= OccW'(DEPTH))
    else $error("occupancy above capacity");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH(DEPTH)
) u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.out_value),
  .out_last_i  (out_o.last),
  .out_status_i(out_o.status),
  .out_occ_i   (out_o.occupancy)
);
